FILE: hw/rtl/tcmr_pkg.sv
// Shared types and constants for the match-reset timer.
// Holds the access codes, register selects and control bit positions.
// No dependencies.
`timescale 1ns / 1ps

package tcmr_pkg;

   // Default counter width, overridable at the top level
   localparam int CounterWidthDefault = 32;

   // Bus data width of the register file
   localparam int DataWidth = 32;

   // Field widths of one request
   localparam int OpWidth  = 2;
   localparam int SelWidth = 3;

   // Access kinds carried by op
   typedef enum logic [OpWidth-1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   // Register selects
   typedef enum logic [SelWidth-1:0] {
      REG_IRQ       = 3'd0,
      REG_CONTROL   = 3'd1,
      REG_COUNTER   = 3'd2,
      REG_MATCH_CTL = 3'd3,
      REG_MATCH_VAL = 3'd4
   } reg_sel_type;

   // Bit positions in control, match control and interrupt registers
   localparam int CtrlEnableBit = 0;
   localparam int CtrlHoldBit   = 1;
   localparam int McFlagBit     = 0;
   localparam int McResetBit    = 1;
   localparam int IrqClearBit   = 0;

   // One request as held in the input register
   typedef struct packed {
      logic [OpWidth-1:0]   op;
      logic [SelWidth-1:0]  reg_sel;
      logic [DataWidth-1:0] write_data;
   } req_item_type;

endpackage

FILE: hw/rtl/tcmr_core.sv
// Timer state and per-item update logic: counter, match value, control,
// match control and interrupt flag. Produces read data and the new flag.
// Depends on tcmr_pkg.
`timescale 1ns / 1ps

module tcmr_core #(
   parameter int COUNTER_WIDTH = tcmr_pkg::CounterWidthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  tcmr_pkg::req_item_type         item,
   output logic [tcmr_pkg::DataWidth-1:0] read_data,
   output logic                           irq_next
);

   logic [COUNTER_WIDTH-1:0] count_ff, count_in;
   logic [COUNTER_WIDTH-1:0] match_value_ff, match_value_in;
   logic [1:0]               control_ff, control_in;
   logic [1:0]               match_ctl_ff, match_ctl_in;
   logic                     flag_ff, flag_in;
   logic [COUNTER_WIDTH-1:0] wdata_cnt;
   logic                     is_match;

   assign wdata_cnt = COUNTER_WIDTH'(item.write_data);
   assign is_match  = (count_ff == match_value_ff);

   // Work out the next state for the item in the input register
   always_comb begin
      count_in       = count_ff;
      match_value_in = match_value_ff;
      control_in     = control_ff;
      match_ctl_in   = match_ctl_ff;
      flag_in        = flag_ff;
      read_data      = '0;
      case (item.op)
         tcmr_pkg::OP_TICK: begin
            if (control_ff[tcmr_pkg::CtrlHoldBit]) begin
               count_in = '0;
            end else if (control_ff[tcmr_pkg::CtrlEnableBit]) begin
               if (is_match && match_ctl_ff[tcmr_pkg::McFlagBit]) begin
                  flag_in = 1'b1;
               end
               if (is_match && match_ctl_ff[tcmr_pkg::McResetBit]) begin
                  count_in = '0;
               end else begin
                  count_in = count_ff + COUNTER_WIDTH'(1);
               end
            end
         end
         tcmr_pkg::OP_READ: begin
            case (item.reg_sel)
               tcmr_pkg::REG_IRQ:       read_data = tcmr_pkg::DataWidth'(flag_ff);
               tcmr_pkg::REG_CONTROL:   read_data = tcmr_pkg::DataWidth'(control_ff);
               tcmr_pkg::REG_COUNTER:   read_data = tcmr_pkg::DataWidth'(count_ff);
               tcmr_pkg::REG_MATCH_CTL: read_data = tcmr_pkg::DataWidth'(match_ctl_ff);
               tcmr_pkg::REG_MATCH_VAL: read_data = tcmr_pkg::DataWidth'(match_value_ff);
               default:                 read_data = '0;
            endcase
         end
         tcmr_pkg::OP_WRITE: begin
            case (item.reg_sel)
               tcmr_pkg::REG_IRQ: begin
                  if (item.write_data[tcmr_pkg::IrqClearBit]) begin
                     flag_in = 1'b0;
                  end
               end
               tcmr_pkg::REG_CONTROL: begin
                  control_in = item.write_data[1:0];
                  if (item.write_data[tcmr_pkg::CtrlHoldBit]) begin
                     count_in = '0;
                  end
               end
               tcmr_pkg::REG_COUNTER: begin
                  if (!control_ff[tcmr_pkg::CtrlHoldBit]) begin
                     count_in = wdata_cnt;
                  end
               end
               tcmr_pkg::REG_MATCH_CTL: match_ctl_in   = item.write_data[1:0];
               tcmr_pkg::REG_MATCH_VAL: match_value_in = wdata_cnt;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign irq_next = flag_in;

   // Commit the new state when the item moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         match_value_ff <= '0;
         control_ff     <= '0;
         match_ctl_ff   <= '0;
         flag_ff        <= 1'b0;
      end else if (fire) begin
         count_ff       <= count_in;
         match_value_ff <= match_value_in;
         control_ff     <= control_in;
         match_ctl_ff   <= match_ctl_in;
         flag_ff        <= flag_in;
      end
   end

endmodule

FILE: hw/rtl/timer_counter_match_reset.sv
// Top level of the match-reset timer: input register, timer core and
// result register with valid/ready handshakes on both sides.
// Depends on tcmr_pkg and tcmr_core.
//
// Usage:
//   Each request item on the req_ channel is a clock tick (op 0), a
//   register read (op 1) or a register write (op 2), with reg_sel picking
//   the interrupt, control, counter, match control or match value register.
//   Every item yields exactly one result item on the rsp_ channel: the read
//   data (zero unless a read) and the interrupt flag after the item.
//   An accepted item waits in the input register, where the timer core
//   updates its state, and moves to the result register when that register
//   is free or draining; rsp_valid then rises. Throughput is one item per
//   cycle while the receiver takes every result, set by the single pass of
//   the core between those two registers.
//   When the receiver stalls, the result register holds its item and the
//   input register takes one more; after that req_ready drops until the
//   result is taken.
//   Synchronous reset clears both registers' valid bits and all timer
//   state: counter, match value and control bits zero, flag clear.
`timescale 1ns / 1ps

module timer_counter_match_reset #(
   parameter int COUNTER_WIDTH = tcmr_pkg::CounterWidthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tcmr_pkg::OpWidth-1:0]        req_op,
   input  logic [tcmr_pkg::SelWidth-1:0]       req_reg_sel,
   input  logic [tcmr_pkg::DataWidth-1:0]      req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tcmr_pkg::DataWidth-1:0]      rsp_read_data,
   output logic                                rsp_irq
);

   logic                               in_valid_ff, in_valid_in;
   tcmr_pkg::req_item_type             in_item_ff;
   logic                               out_valid_ff, out_valid_in;
   logic [tcmr_pkg::DataWidth-1:0]     out_data_ff;
   logic                               out_irq_ff;
   logic                               advance;
   logic                               req_fire;
   logic [tcmr_pkg::DataWidth-1:0]     core_read_data;
   logic                               core_irq;

   // Move the held item on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // Hold valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.op         <= req_op;
         in_item_ff.reg_sel    <= req_reg_sel;
         in_item_ff.write_data <= req_write_data;
      end
   end

   tcmr_core #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .item     (in_item_ff),
      .read_data(core_read_data),
      .irq_next (core_irq)
   );

   // Capture the result
   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_read_data;
         out_irq_ff  <= core_irq;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;
   assign rsp_irq       = out_irq_ff;

endmodule

FILE: verif/tb_top.sv
// Testbench for the match-reset timer: drives ticks and register accesses
// on the req_ channel and checks every rsp_ item against a timer predictor.
// Depends on tcmr_pkg and timer_counter_match_reset.
`timescale 1ns / 1ps

module tb_top;

   localparam int CntWidth   = tcmr_pkg::CounterWidthDefault;
   localparam int DataWidth  = tcmr_pkg::DataWidth;
   localparam int OpWidth    = tcmr_pkg::OpWidth;
   localparam int SelWidth   = tcmr_pkg::SelWidth;
   localparam int CycleLimit = 200000;
   localparam int IdlePct    = 13;
   localparam int LongHold   = 60;
   localparam int DrainWait  = 10;
   localparam int RandItems  = 1750;

   // Codes outside the decoded ranges
   localparam logic [OpWidth-1:0]  OpUndefined   = 2'd3;
   localparam logic [SelWidth-1:0] RegUnmapped   = 3'd5;
   localparam logic [SelWidth-1:0] RegUnmappedHi = 3'd7;

   // Timer predictor and queue of predicted responses
   class timer_scoreboard;
      typedef struct {
         logic [DataWidth-1:0] read_data;
         logic                 irq;
      } timer_rsp_type;

      logic [CntWidth-1:0] count;
      logic [CntWidth-1:0] match_value;
      logic [1:0]          control;
      logic [1:0]          match_ctl;
      logic                flag;
      timer_rsp_type       expected_rsp_q[$];
      int                  errors;

      function new();
         count       = '0;
         match_value = '0;
         control     = '0;
         match_ctl   = '0;
         flag        = 1'b0;
         errors      = 0;
      endfunction

      // Advance the timer model by one accepted item and queue its response
      function void note_access(logic [OpWidth-1:0] op, logic [SelWidth-1:0] sel,
                                logic [DataWidth-1:0] data);
         timer_rsp_type rsp;
         rsp.read_data = '0;
         case (op)
            tcmr_pkg::OP_TICK: begin
               if (control[tcmr_pkg::CtrlHoldBit]) begin
                  count = '0;
               end else if (control[tcmr_pkg::CtrlEnableBit]) begin
                  if (count == match_value && match_ctl[tcmr_pkg::McFlagBit])
                     flag = 1'b1;
                  if (count == match_value && match_ctl[tcmr_pkg::McResetBit])
                     count = '0;
                  else
                     count = count + 1'b1;
               end
            end
            tcmr_pkg::OP_READ: begin
               case (sel)
                  tcmr_pkg::REG_IRQ:       rsp.read_data = DataWidth'(flag);
                  tcmr_pkg::REG_CONTROL:   rsp.read_data = DataWidth'(control);
                  tcmr_pkg::REG_COUNTER:   rsp.read_data = DataWidth'(count);
                  tcmr_pkg::REG_MATCH_CTL: rsp.read_data = DataWidth'(match_ctl);
                  tcmr_pkg::REG_MATCH_VAL: rsp.read_data = DataWidth'(match_value);
                  default:                 rsp.read_data = '0;
               endcase
            end
            tcmr_pkg::OP_WRITE: begin
               case (sel)
                  tcmr_pkg::REG_IRQ: begin
                     if (data[tcmr_pkg::IrqClearBit])
                        flag = 1'b0;
                  end
                  tcmr_pkg::REG_CONTROL: begin
                     control = data[1:0];
                     if (control[tcmr_pkg::CtrlHoldBit])
                        count = '0;
                  end
                  tcmr_pkg::REG_COUNTER: begin
                     if (!control[tcmr_pkg::CtrlHoldBit])
                        count = CntWidth'(data);
                  end
                  tcmr_pkg::REG_MATCH_CTL: match_ctl = data[1:0];
                  tcmr_pkg::REG_MATCH_VAL: match_value = CntWidth'(data);
                  default: ;
               endcase
            end
            default: ;
         endcase
         rsp.irq = flag;
         expected_rsp_q.push_back(rsp);
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_response(logic [DataWidth-1:0] read_data, logic irq);
         timer_rsp_type exp_rsp;
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected response: read_data %h irq %b", read_data, irq);
            errors++;
            return;
         end
         exp_rsp = expected_rsp_q.pop_front();
         if (read_data !== exp_rsp.read_data) begin
            $error("read_data: expected %h, actual %h", exp_rsp.read_data, read_data);
            errors++;
         end
         if (irq !== exp_rsp.irq) begin
            $error("irq: expected %b, actual %b", exp_rsp.irq, irq);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      function void report_leftover();
         if (expected_rsp_q.size() != 0) begin
            $error("%0d responses never arrived", expected_rsp_q.size());
            errors++;
         end
      endfunction
   endclass

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [OpWidth-1:0]   req_op         = '0;
   logic [SelWidth-1:0]  req_reg_sel    = '0;
   logic [DataWidth-1:0] req_write_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [DataWidth-1:0] rsp_read_data;
   logic                 rsp_irq;

   // Written by the sender, read by the receiver; cycle_count is kept by the abort block
   logic                 no_idle        = 1'b0;
   int                   holds_asked    = 0;
   int                   items_sent     = 0;
   int                   cycle_count    = 0;

   timer_scoreboard sb = new();

   timer_counter_match_reset #(
      .COUNTER_WIDTH(CntWidth)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_reg_sel   (req_reg_sel),
      .req_write_data(req_write_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_data (rsp_read_data),
      .rsp_irq       (rsp_irq)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offer one item, with random idle cycles ahead of it, and hold it until taken
   task automatic send_item(input logic [OpWidth-1:0] op, input logic [SelWidth-1:0] sel,
                            input logic [DataWidth-1:0] data);
      while (!no_idle && $urandom_range(99) < IdlePct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_reg_sel    <= sel;
      req_write_data <= data;
      do @(posedge clock); while (!req_ready);
      sb.note_access(op, sel, data);
      items_sent++;
   endtask

   // Stop offering until every predicted response has come back
   task automatic wait_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic logic [SelWidth-1:0] pick_sel();
      if ($urandom_range(9) < 8)
         return SelWidth'($urandom_range(4));
      return SelWidth'($urandom_range(7));
   endfunction

   // One item inside a counting stretch: mostly ticks and reads
   task automatic send_body_item();
      int r;
      r = $urandom_range(99);
      if (r < 55)
         send_item(tcmr_pkg::OP_TICK, pick_sel(), $urandom());
      else if (r < 75)
         send_item(tcmr_pkg::OP_READ, pick_sel(), $urandom());
      else if (r < 85)
         send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_IRQ, $urandom());
      else if (r < 89)
         send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_CONTROL, $urandom());
      else if (r < 93)
         send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_COUNTER, ($urandom_range(1) == 0) ?
                   DataWidth'($urandom_range(15)) : $urandom());
      else if (r < 96)
         send_item(OpUndefined, SelWidth'($urandom_range(7)), $urandom());
      else
         send_item(tcmr_pkg::OP_WRITE, SelWidth'($urandom_range(7)), $urandom());
   endtask

   // Set up match value, actions, counter and control, then run a stretch
   task automatic run_episode();
      logic [DataWidth-1:0] mv;
      logic [DataWidth-1:0] ctl;
      int                   n;
      mv = ($urandom_range(3) == 0) ? $urandom() : DataWidth'($urandom_range(12));
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_MATCH_VAL, mv);
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_MATCH_CTL, $urandom());
      case ($urandom_range(3))
         0:       send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_COUNTER, $urandom());
         1:       send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_COUNTER,
                            mv - DataWidth'($urandom_range(3)));
         default: send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_COUNTER,
                            DataWidth'($urandom_range(8)));
      endcase
      ctl = $urandom();
      if ($urandom_range(3) != 0)
         ctl[1:0] = 2'b01;
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_CONTROL, ctl);
      n = $urandom_range(40, 8);
      repeat (n)
         send_body_item();
   endtask

   // Receiver: check taken responses, idle at random, serve long hold-offs
   initial begin
      int stall_left;
      int holds_served;
      stall_left   = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_read_data, rsp_irq);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            stall_left = LongHold;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= IdlePct);
         end
      end
   end

   // Sender: reset, directed items, random episodes, drain and verdict
   initial begin
      int  target;
      bit  held;
      bit  paused;
      held   = 1'b0;
      paused = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values and an unmapped read
      send_item(tcmr_pkg::OP_READ, tcmr_pkg::REG_IRQ, '0);
      send_item(tcmr_pkg::OP_READ, tcmr_pkg::REG_CONTROL, '1);
      send_item(tcmr_pkg::OP_READ, tcmr_pkg::REG_COUNTER, '0);
      send_item(tcmr_pkg::OP_READ, tcmr_pkg::REG_MATCH_CTL, '0);
      send_item(tcmr_pkg::OP_READ, tcmr_pkg::REG_MATCH_VAL, '0);
      send_item(tcmr_pkg::OP_READ, RegUnmappedHi, '1);
      // Match at the top value with flag and reset-on-match
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_MATCH_VAL, '1);
      send_item(tcmr_pkg::OP_READ, tcmr_pkg::REG_MATCH_VAL, '0);
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_COUNTER, '1);
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_MATCH_CTL, '1);
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_CONTROL, 32'hFFFF_FFFD);
      send_item(tcmr_pkg::OP_TICK, tcmr_pkg::REG_IRQ, '1);
      send_item(tcmr_pkg::OP_READ, tcmr_pkg::REG_COUNTER, '0);
      // Match with no actions: counter wraps
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_MATCH_CTL, '0);
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_COUNTER, '1);
      send_item(tcmr_pkg::OP_TICK, tcmr_pkg::REG_IRQ, '0);
      send_item(tcmr_pkg::OP_READ, tcmr_pkg::REG_COUNTER, '0);
      // Flag clear needs bit0
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_IRQ, 32'hFFFF_FFFE);
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_IRQ, 32'h0000_0001);
      // Counter held at zero: tick and write have no effect
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_CONTROL, 32'h0000_0003);
      send_item(tcmr_pkg::OP_TICK, tcmr_pkg::REG_COUNTER, '0);
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_COUNTER, 32'h0000_1234);
      send_item(tcmr_pkg::OP_READ, tcmr_pkg::REG_COUNTER, '0);
      // Disabled tick, undefined op, unmapped write
      send_item(tcmr_pkg::OP_WRITE, tcmr_pkg::REG_CONTROL, '0);
      send_item(tcmr_pkg::OP_TICK, tcmr_pkg::REG_IRQ, '0);
      send_item(OpUndefined, RegUnmapped, '1);
      send_item(tcmr_pkg::OP_WRITE, RegUnmapped, '1);

      target = items_sent + RandItems;
      while (items_sent < target) begin
         run_episode();
         no_idle <= (items_sent > target - 900 && items_sent < target - 650);
         if (!held && items_sent > target - 1200) begin
            held = 1'b1;
            holds_asked <= holds_asked + 1;
         end
         if (!paused && items_sent > target - 500) begin
            paused = 1'b1;
            wait_responses();
         end
      end

      // Drain: all predictions answered, then a quiet wait and the verdict
      wait_responses();
      repeat (DrainWait) @(posedge clock);
      sb.report_leftover();
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
